@@ src/mnva_pkg.sv @@
// shared types and constants of the midi note voice allocator
`default_nettype none

package mnva_pkg;

   // storage and value constants
   localparam int          NOTE_SLOTS_DEFAULT = 16;
   localparam logic [7:0]  EMPTY_NOTE         = 8'hFF;
   localparam logic [3:0]  ALL_VOICES         = 4'hF;
   localparam logic [15:0] TRACK_FULL         = 16'h8000;
   localparam logic [3:0]  DIV_LAST_STEP      = 4'd14;

   // reset values of the control registers
   localparam logic [6:0]  ZERO_KEY_RESET     = 7'd36;
   localparam logic [6:0]  TRACK_LOW_RESET    = 7'd36;
   localparam logic [6:0]  TRACK_HIGH_RESET   = 7'd96;

   // note assignment modes
   typedef enum logic [2:0] {
      MODE_MONO_LOW  = 3'd0,
      MODE_MONO_HIGH = 3'd1,
      MODE_MONO_LAST = 3'd2,
      MODE_POLY_FREE = 3'd3,
      MODE_POLY_RR   = 3'd4
   } mode_type;

   localparam mode_type MODE_RESET = MODE_MONO_LAST;

   // control register indexes
   typedef enum logic [2:0] {
      CSR_MODE       = 3'd0,
      CSR_GATE_HOLD  = 3'd1,
      CSR_ZERO_KEY   = 3'd2,
      CSR_TRACK_LOW  = 3'd3,
      CSR_TRACK_HIGH = 3'd4
   } csr_index_type;

   // datapath commands
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_FREE_FIND,
      OP_CLEAR_SCAN,
      OP_MINMAX_SCAN,
      OP_CIRC_STORE,
      OP_WALK,
      OP_WALK_LOAD,
      OP_RR_STORE,
      OP_MONO_OUT,
      OP_POLY_OUT,
      OP_DIV_SETUP,
      OP_DIV_STEP,
      OP_LOAD_OUT
   } dp_op_type;

   // controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FREE,
      S_CLEAR,
      S_MINMAX,
      S_CIRC,
      S_WALK,
      S_LOAD,
      S_RR,
      S_MONO,
      S_POLY,
      S_DSETUP,
      S_DSTEP,
      S_DONE
   } state_type;

   // datapath status back to the controller
   typedef struct packed {
      logic     done;
      logic     hit;
      logic     on;
      mode_type mode;
   } dp_status_type;

   // result beat payload
   typedef struct packed {
      logic signed [7:0] pitch0;
      logic signed [7:0] pitch1;
      logic signed [7:0] pitch2;
      logic signed [7:0] pitch3;
      logic [3:0]        voice_gates;
      logic [3:0]        voice_triggers;
      logic              common_gate;
      logic              common_trigger;
      logic [15:0]       key_track;
   } rsp_payload_type;

endpackage

`default_nettype wire

@@ src/mnva_if.sv @@
// request and response channel interfaces
`default_nettype none

interface mnva_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] note_number;
   logic       pressed;

   modport source (output valid, output note_number, output pressed, input ready);
   modport sink   (input valid, input note_number, input pressed, output ready);
endinterface

interface mnva_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] pitch0;
   logic signed [7:0] pitch1;
   logic signed [7:0] pitch2;
   logic signed [7:0] pitch3;
   logic [3:0]        voice_gates;
   logic [3:0]        voice_triggers;
   logic              common_gate;
   logic              common_trigger;
   logic [15:0]       key_track;

   modport source (output valid, output pitch0, output pitch1, output pitch2, output pitch3,
                   output voice_gates, output voice_triggers, output common_gate,
                   output common_trigger, output key_track, input ready);
   modport sink   (input valid, input pitch0, input pitch1, input pitch2, input pitch3,
                   input voice_gates, input voice_triggers, input common_gate,
                   input common_trigger, input key_track, output ready);
endinterface

`default_nettype wire

@@ src/mnva_ctrl.sv @@
// controller state machine of the voice allocator
`default_nettype none

module mnva_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire mnva_pkg::dp_status_type status,
   output mnva_pkg::dp_op_type         op
);

   mnva_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mnva_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == mnva_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      op           = mnva_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         mnva_pkg::S_IDLE: begin
            if (req_valid) begin
               op       = mnva_pkg::OP_LATCH;
               state_in = mnva_pkg::S_DISPATCH;
            end
         end
         mnva_pkg::S_DISPATCH: begin
            if (status.mode == mnva_pkg::MODE_MONO_LAST) begin
               state_in = status.on ? mnva_pkg::S_CIRC : mnva_pkg::S_CLEAR;
            end else if (status.mode == mnva_pkg::MODE_POLY_RR) begin
               state_in = mnva_pkg::S_RR;
            end else begin
               state_in = status.on ? mnva_pkg::S_FREE : mnva_pkg::S_CLEAR;
            end
         end
         mnva_pkg::S_FREE: begin
            op = mnva_pkg::OP_FREE_FIND;
            if (status.done) begin
               state_in = (status.mode == mnva_pkg::MODE_POLY_FREE) ?
                          mnva_pkg::S_POLY : mnva_pkg::S_MINMAX;
            end
         end
         mnva_pkg::S_CLEAR: begin
            op = mnva_pkg::OP_CLEAR_SCAN;
            if (status.done) begin
               if (status.mode == mnva_pkg::MODE_MONO_LAST) begin
                  state_in = mnva_pkg::S_WALK;
               end else if (status.mode == mnva_pkg::MODE_POLY_FREE) begin
                  state_in = mnva_pkg::S_POLY;
               end else begin
                  state_in = mnva_pkg::S_MINMAX;
               end
            end
         end
         mnva_pkg::S_MINMAX: begin
            op = mnva_pkg::OP_MINMAX_SCAN;
            if (status.done) state_in = mnva_pkg::S_MONO;
         end
         mnva_pkg::S_CIRC: begin
            op = mnva_pkg::OP_CIRC_STORE;
            if (status.done) state_in = mnva_pkg::S_MONO;
         end
         mnva_pkg::S_WALK: begin
            op = mnva_pkg::OP_WALK;
            if (status.done) state_in = status.hit ? mnva_pkg::S_LOAD : mnva_pkg::S_MONO;
         end
         mnva_pkg::S_LOAD: begin
            op       = mnva_pkg::OP_WALK_LOAD;
            state_in = mnva_pkg::S_MONO;
         end
         mnva_pkg::S_RR: begin
            op       = mnva_pkg::OP_RR_STORE;
            state_in = mnva_pkg::S_POLY;
         end
         mnva_pkg::S_MONO: begin
            op       = mnva_pkg::OP_MONO_OUT;
            state_in = status.hit ? mnva_pkg::S_DSETUP : mnva_pkg::S_DONE;
         end
         mnva_pkg::S_POLY: begin
            op       = mnva_pkg::OP_POLY_OUT;
            state_in = status.hit ? mnva_pkg::S_DSETUP : mnva_pkg::S_DONE;
         end
         mnva_pkg::S_DSETUP: begin
            op       = mnva_pkg::OP_DIV_SETUP;
            state_in = status.hit ? mnva_pkg::S_DONE : mnva_pkg::S_DSTEP;
         end
         mnva_pkg::S_DSTEP: begin
            op = mnva_pkg::OP_DIV_STEP;
            if (status.done) state_in = mnva_pkg::S_DONE;
         end
         mnva_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op           = mnva_pkg::OP_LOAD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = mnva_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mnva_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/mnva_dpath.sv @@
// datapath: note memory, voice state, keytrack divider and output register
`default_nettype none

module mnva_dpath #(
   parameter int NOTE_SLOTS = mnva_pkg::NOTE_SLOTS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mnva_pkg::dp_op_type     op,
   output mnva_pkg::dp_status_type      status,
   input  wire logic [6:0]              req_note_number,
   input  wire logic                    req_pressed,
   input  wire logic                    csr_write_enable,
   input  wire logic [2:0]              csr_index,
   input  wire logic [6:0]              csr_write_data,
   output mnva_pkg::rsp_payload_type    rsp_payload
);

   localparam int AW = $clog2(NOTE_SLOTS);
   localparam int CW = AW + 1;

   // control registers
   mnva_pkg::mode_type mode_ff, mode_in;
   logic               gate_hold_ff, gate_hold_in;
   logic [6:0]         zero_key_ff, zero_key_in;
   logic [6:0]         track_low_ff, track_low_in;
   logic [6:0]         track_high_ff, track_high_in;

   // note memory with per-slot valid bits; slots 0..3 mirrored for the poly modes
   logic [6:0]            note_mem [NOTE_SLOTS];
   logic [6:0]            rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [NOTE_SLOTS-1:0] vld_ff, vld_in;
   logic [6:0]            shadow_ff [4];
   logic [6:0]            shadow_in [4];

   // event and scan state
   logic [6:0]    note_ff, note_in;
   logic          on_ff, on_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic          found_ff, found_in;
   logic [6:0]    top_ff, top_in;
   logic [6:0]    bot_ff, bot_in;

   // voice state
   logic [7:0]  owner_ff [4];
   logic [7:0]  owner_in [4];
   logic [7:0]  last_ff [4];
   logic [7:0]  last_in [4];
   logic [7:0]  pitch_ff [4];
   logic [7:0]  pitch_in [4];
   logic [3:0]  gate_ff, gate_in;
   logic [3:0]  trig_ff, trig_in;
   logic [3:0]  snap_ff [2];
   logic [3:0]  snap_in [2];
   logic [6:0]  mlp_ff [3];
   logic [6:0]  mlp_in [3];
   logic        ct_ff, ct_in;
   logic [15:0] track_ff, track_in;

   // keytrack divider
   logic [6:0]  div_note_ff, div_note_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  den_ff, den_in;
   logic [13:0] quo_ff, quo_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;

   mnva_pkg::rsp_payload_type out_ff, out_in;

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] i);
      if (i == AW'(NOTE_SLOTS - 1)) return '0;
      return i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] i);
      if (i == '0) return AW'(NOTE_SLOTS - 1);
      return i - AW'(1);
   endfunction

   assign rsp_payload = out_ff;

   // note memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) note_mem[wr_addr] <= note_ff;
      rd_data_ff <= note_mem[rd_addr];
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mnva_pkg::MODE_RESET;
         gate_hold_ff  <= 1'b0;
         zero_key_ff   <= mnva_pkg::ZERO_KEY_RESET;
         track_low_ff  <= mnva_pkg::TRACK_LOW_RESET;
         track_high_ff <= mnva_pkg::TRACK_HIGH_RESET;
         vld_ff        <= '0;
         wp_ff         <= '0;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         gate_ff       <= '0;
         trig_ff       <= '0;
         ct_ff         <= 1'b0;
         track_ff      <= '0;
         div_cnt_ff    <= '0;
         for (int i = 0; i < 4; i++) begin
            owner_ff[i] <= mnva_pkg::EMPTY_NOTE;
            last_ff[i]  <= mnva_pkg::EMPTY_NOTE;
            pitch_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) snap_ff[i] <= '0;
         for (int i = 0; i < 3; i++) mlp_ff[i] <= '0;
      end else begin
         mode_ff       <= mode_in;
         gate_hold_ff  <= gate_hold_in;
         zero_key_ff   <= zero_key_in;
         track_low_ff  <= track_low_in;
         track_high_ff <= track_high_in;
         vld_ff        <= vld_in;
         wp_ff         <= wp_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         gate_ff       <= gate_in;
         trig_ff       <= trig_in;
         ct_ff         <= ct_in;
         track_ff      <= track_in;
         div_cnt_ff    <= div_cnt_in;
         owner_ff      <= owner_in;
         last_ff       <= last_in;
         pitch_ff      <= pitch_in;
         snap_ff       <= snap_in;
         mlp_ff        <= mlp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      note_ff     <= note_in;
      on_ff       <= on_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      shadow_ff   <= shadow_in;
      div_note_ff <= div_note_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      out_ff      <= out_in;
   end

   // command decode and next-state logic
   always_comb begin
      logic [CW-1:0]     cnt_m1;
      logic [AW-1:0]     slot;
      logic [AW-1:0]     wa;
      logic              do_store;
      logic              m_hit;
      logic [1:0]        m_idx;
      logic              p_hit;
      logic [1:0]        p_sel;
      logic [1:0]        q;
      logic              rr;
      logic              any;
      logic [6:0]        ptop;
      logic [7:0]        e;
      logic [3:0]        bitv;
      logic [1:0]        midx;
      logic [6:0]        sel;
      logic signed [7:0] num;
      logic signed [7:0] den;
      logic [7:0]        r2;
      logic              qb;

      mode_in       = mode_ff;
      gate_hold_in  = gate_hold_ff;
      zero_key_in   = zero_key_ff;
      track_low_in  = track_low_ff;
      track_high_in = track_high_ff;
      vld_in        = vld_ff;
      shadow_in     = shadow_ff;
      note_in       = note_ff;
      on_in         = on_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      found_in      = found_ff;
      top_in        = top_ff;
      bot_in        = bot_ff;
      owner_in      = owner_ff;
      last_in       = last_ff;
      pitch_in      = pitch_ff;
      gate_in       = gate_ff;
      trig_in       = trig_ff;
      snap_in       = snap_ff;
      mlp_in        = mlp_ff;
      ct_in         = ct_ff;
      track_in      = track_ff;
      div_note_in   = div_note_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      out_in        = out_ff;

      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      rd_addr = cnt_ff[AW-1:0];

      status      = '0;
      status.mode = mode_ff;
      status.on   = on_ff;

      cnt_m1   = cnt_ff - CW'(1);
      slot     = cnt_m1[AW-1:0];
      wa       = '0;
      do_store = 1'b0;
      m_hit    = 1'b0;
      m_idx    = '0;
      p_hit    = 1'b0;
      p_sel    = wp_ff[1:0];
      q        = '0;
      rr       = (mode_ff == mnva_pkg::MODE_POLY_RR);
      any      = 1'b0;
      ptop     = '0;
      e        = '0;
      bitv     = '0;
      midx     = '0;
      sel      = '0;
      num      = '0;
      den      = '0;
      r2       = '0;
      qb       = 1'b0;

      // control register writes, out-of-range modes ignored
      if (csr_write_enable) begin
         unique case (mnva_pkg::csr_index_type'(csr_index))
            mnva_pkg::CSR_MODE: begin
               if (csr_write_data[2:0] <= 3'(mnva_pkg::MODE_POLY_RR)) begin
                  mode_in = mnva_pkg::mode_type'(csr_write_data[2:0]);
               end
            end
            mnva_pkg::CSR_GATE_HOLD:  gate_hold_in  = csr_write_data[0];
            mnva_pkg::CSR_ZERO_KEY:   zero_key_in   = csr_write_data;
            mnva_pkg::CSR_TRACK_LOW:  track_low_in  = csr_write_data;
            mnva_pkg::CSR_TRACK_HIGH: track_high_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (op)
         mnva_pkg::OP_NONE: ;

         // take the event beat
         mnva_pkg::OP_LATCH: begin
            note_in  = req_note_number;
            on_in    = req_pressed;
            cnt_in   = '0;
            idx_in   = wp_ff;
            found_in = 1'b0;
         end

         // first empty slot, dropped when full
         mnva_pkg::OP_FREE_FIND: begin
            if (!vld_ff[cnt_ff[AW-1:0]]) begin
               wr_en                    = 1'b1;
               wr_addr                  = cnt_ff[AW-1:0];
               vld_in[cnt_ff[AW-1:0]]   = 1'b1;
               status.done              = 1'b1;
               cnt_in                   = '0;
            end else if (cnt_ff == CW'(NOTE_SLOTS - 1)) begin
               status.done = 1'b1;
               cnt_in      = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         // pipelined scans: read slot cnt, evaluate slot cnt-1
         mnva_pkg::OP_CLEAR_SCAN, mnva_pkg::OP_MINMAX_SCAN: begin
            if (cnt_ff != '0 && vld_ff[slot]) begin
               if (op == mnva_pkg::OP_CLEAR_SCAN) begin
                  if (rd_data_ff == note_ff) vld_in[slot] = 1'b0;
               end else begin
                  if (!found_ff || rd_data_ff > top_ff) top_in = rd_data_ff;
                  if (!found_ff || rd_data_ff < bot_ff) bot_in = rd_data_ff;
                  found_in = 1'b1;
               end
            end
            if (cnt_ff == CW'(NOTE_SLOTS)) begin
               status.done = 1'b1;
               cnt_in      = '0;
               idx_in      = wp_ff;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end

         // circular store: walk back to the newest held note and store after it, or at slot 0 when none is held
         mnva_pkg::OP_CIRC_STORE: begin
            if (vld_ff[idx_ff]) begin
               wa       = slot_inc(idx_ff);
               do_store = 1'b1;
            end else if (slot_dec(idx_ff) == wp_ff) begin
               wa       = '0;
               do_store = 1'b1;
            end else begin
               idx_in = slot_dec(idx_ff);
            end
            if (do_store) begin
               wr_en       = 1'b1;
               wr_addr     = wa;
               vld_in[wa]  = 1'b1;
               wp_in       = wa;
               found_in    = 1'b1;
               top_in      = note_ff;
               bot_in      = note_ff;
               status.done = 1'b1;
            end
         end

         // newest held note after a note off
         mnva_pkg::OP_WALK: begin
            rd_addr = idx_ff;
            if (vld_ff[idx_ff]) begin
               status.done = 1'b1;
               status.hit  = 1'b1;
               cnt_in      = '0;
            end else if (cnt_ff == CW'(NOTE_SLOTS - 1)) begin
               status.done = 1'b1;
               found_in    = 1'b0;
               cnt_in      = '0;
            end else begin
               idx_in = slot_dec(idx_ff);
               cnt_in = cnt_ff + CW'(1);
            end
         end

         mnva_pkg::OP_WALK_LOAD: begin
            found_in = 1'b1;
            top_in   = rd_data_ff;
            bot_in   = rd_data_ff;
         end

         // round robin store over voices 0..3, or release of the matching slots on a note off
         mnva_pkg::OP_RR_STORE: begin
            status.done = 1'b1;
            if (on_ff) begin
               for (int i = 0; i < 4; i++) begin
                  if (!m_hit && owner_ff[i] == {1'b0, note_ff}) begin
                     m_hit = 1'b1;
                     m_idx = 2'(i);
                  end
               end
               if (m_hit) begin
                  wr_en             = 1'b1;
                  wr_addr           = AW'(m_idx);
                  vld_in[AW'(m_idx)] = 1'b1;
               end else begin
                  for (int k = 0; k < 4; k++) begin
                     q = wp_ff[1:0] + 2'(k);
                     if (!p_hit && !vld_ff[AW'(q)]) begin
                        p_hit = 1'b1;
                        p_sel = q;
                     end
                  end
                  wr_en              = 1'b1;
                  wr_addr            = AW'(p_sel);
                  vld_in[AW'(p_sel)] = 1'b1;
                  owner_in[p_sel]    = {1'b0, note_ff};
                  wp_in              = AW'(2'(p_sel + 2'd1));
               end
            end else begin
               for (int i = 0; i < 4; i++) begin
                  if (vld_ff[i] && shadow_ff[i] == note_ff) vld_in[i] = 1'b0;
               end
            end
         end

         // mono voice update
         mnva_pkg::OP_MONO_OUT: begin
            unique case (mode_ff)
               mnva_pkg::MODE_MONO_LOW:  midx = 2'd0;
               mnva_pkg::MODE_MONO_HIGH: midx = 2'd1;
               default:                  midx = 2'd2;
            endcase
            sel = (mode_ff == mnva_pkg::MODE_MONO_LOW) ? bot_ff : top_ff;
            if (found_ff) begin
               for (int i = 0; i < 4; i++) pitch_in[i] = {1'b0, sel} - {1'b0, zero_key_ff};
               if (!gate_ff[0]) trig_in = trig_ff ^ mnva_pkg::ALL_VOICES;
               gate_in = mnva_pkg::ALL_VOICES;
               if (sel != mlp_ff[midx]) ct_in = ~ct_ff;
               mlp_in[midx] = sel;
               div_note_in  = top_ff;
               status.hit   = 1'b1;
            end else begin
               gate_in      = gate_hold_ff ? mnva_pkg::ALL_VOICES : 4'h0;
               mlp_in[midx] = '0;
            end
         end

         // poly voice update from slots 0..3
         mnva_pkg::OP_POLY_OUT: begin
            for (int i = 0; i < 4; i++) begin
               e    = vld_ff[i] ? {1'b0, shadow_ff[i]} : mnva_pkg::EMPTY_NOTE;
               bitv = 4'(1 << i);
               if (!(rr && e == last_ff[i])) begin
                  if (e != mnva_pkg::EMPTY_NOTE) begin
                     pitch_in[i] = e - {1'b0, zero_key_ff};
                     gate_in     = gate_in | bitv;
                     if (e != last_ff[i]) trig_in = trig_in ^ bitv;
                     if (!any || e[6:0] > ptop) ptop = e[6:0];
                     any = 1'b1;
                  end else if (gate_hold_ff) begin
                     gate_in = gate_in | bitv;
                  end else begin
                     gate_in = gate_in & ~bitv;
                  end
               end
               last_in[i] = e;
            end
            if (trig_in != snap_ff[rr]) begin
               snap_in[rr] = trig_in;
               ct_in       = ~ct_ff;
            end
            div_note_in = ptop;
            status.hit  = !rr && any;
         end

         // keytrack: edge cases direct, otherwise bit-serial divide
         mnva_pkg::OP_DIV_SETUP: begin
            num = {1'b0, div_note_ff} - {1'b0, track_low_ff};
            den = {1'b0, track_high_ff} - {1'b0, track_low_ff};
            if (den == '0) begin
               track_in   = mnva_pkg::TRACK_FULL;
               status.hit = 1'b1;
            end else begin
               if (den < 0) begin
                  den = -den;
                  num = -num;
               end
               if (num <= 0) begin
                  track_in   = '0;
                  status.hit = 1'b1;
               end else if (num >= den) begin
                  track_in   = mnva_pkg::TRACK_FULL;
                  status.hit = 1'b1;
               end else begin
                  rem_in     = num[6:0];
                  den_in     = den[6:0];
                  quo_in     = '0;
                  div_cnt_in = '0;
               end
            end
         end

         mnva_pkg::OP_DIV_STEP: begin
            r2 = {rem_ff, 1'b0};
            if (r2 >= {1'b0, den_ff}) begin
               rem_in = 7'(r2 - {1'b0, den_ff});
               qb     = 1'b1;
            end else begin
               rem_in = r2[6:0];
            end
            quo_in = {quo_ff[12:0], qb};
            if (div_cnt_ff == mnva_pkg::DIV_LAST_STEP) begin
               track_in    = {1'b0, quo_ff, qb};
               status.done = 1'b1;
            end else begin
               div_cnt_in = div_cnt_ff + 4'd1;
            end
         end

         // result beat
         mnva_pkg::OP_LOAD_OUT: begin
            out_in.pitch0         = pitch_ff[0];
            out_in.pitch1         = pitch_ff[1];
            out_in.pitch2         = pitch_ff[2];
            out_in.pitch3         = pitch_ff[3];
            out_in.voice_gates    = gate_ff;
            out_in.voice_triggers = trig_ff;
            out_in.common_gate    = |gate_ff;
            out_in.common_trigger = ct_ff;
            out_in.key_track      = track_ff;
         end

         default: ;
      endcase

      // mirror of slots 0..3
      if (wr_en && int'(wr_addr) < 4) shadow_in[wr_addr[1:0]] = note_ff;
   end

endmodule

`default_nettype wire

@@ src/midi_note_voice_allocator_top.sv @@
// top level of the midi note to four-voice cv allocator
// Usage: note events enter on req_bus (note_number, pressed) with valid/ready;
// each event gives exactly one beat on rsp_bus with the four voice pitches,
// gate and trigger bits, the common gate and trigger, and the Q1.15 keytrack.
// Control registers (mode, gate_hold, zero_key, track_low, track_high) are
// written through csr_write_enable/csr_index/csr_write_data while idle.
// One event is processed at a time; the next event can be taken in the cycle
// after the beat is loaded. The note memory, with one write and one read port,
// is scanned one slot per cycle, and the keytrack comes from a 15-step
// bit-serial divider.
// Reset (synchronous, active high) empties the note memory through its valid
// bits at once and restores the register defaults; no clearing pass is run.
// A finished beat waits in the output register while the next event is
// already taken; if the receiver stalls, work on that event halts at its end
// until the waiting beat is taken.
`default_nettype none

module midi_note_voice_allocator_top #(
   parameter int NOTE_SLOTS = mnva_pkg::NOTE_SLOTS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   mnva_req_if.sink        req_bus,
   mnva_rsp_if.source      rsp_bus,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_index,
   input  wire logic [6:0] csr_write_data
);

   mnva_pkg::dp_op_type       op;
   mnva_pkg::dp_status_type   status;
   mnva_pkg::rsp_payload_type payload;

   // controller
   mnva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .op        (op)
   );

   // datapath
   mnva_dpath #(
      .NOTE_SLOTS (NOTE_SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .status           (status),
      .req_note_number  (req_bus.note_number),
      .req_pressed      (req_bus.pressed),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_payload      (payload)
   );

   // result beat fields
   assign rsp_bus.pitch0         = payload.pitch0;
   assign rsp_bus.pitch1         = payload.pitch1;
   assign rsp_bus.pitch2         = payload.pitch2;
   assign rsp_bus.pitch3         = payload.pitch3;
   assign rsp_bus.voice_gates    = payload.voice_gates;
   assign rsp_bus.voice_triggers = payload.voice_triggers;
   assign rsp_bus.common_gate    = payload.common_gate;
   assign rsp_bus.common_trigger = payload.common_trigger;
   assign rsp_bus.key_track      = payload.key_track;

endmodule

`default_nettype wire

@@ sim/tb_midi_note_voice_allocator_top.sv @@
// self-checking testbench of the midi note voice allocator top level
`timescale 1ns / 100ps
`default_nettype none

module tb_midi_note_voice_allocator_top;

   localparam int SLOTS      = 16;
   localparam int SETTLE     = 80;
   localparam int LONG_HOLD  = 400;
   localparam int PHASES     = 20;
   localparam int PHASE_LEN  = 80;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [2:0] csr_index;
   logic [6:0] csr_write_data;

   mnva_req_if req_bus ();
   mnva_rsp_if rsp_bus ();

   midi_note_voice_allocator_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow registers
   mnva_pkg::mode_type cfg_mode;
   logic               cfg_gate_hold;
   logic [6:0]         cfg_zero_key;
   logic [6:0]         cfg_track_low;
   logic [6:0]         cfg_track_high;

   // shadow allocator state
   logic [7:0]  slot_note [SLOTS];
   logic [3:0]  slot_ptr;
   logic [7:0]  voice_prev [4];
   logic [7:0]  voice_owner [4];
   logic [7:0]  voice_pitch [4];
   logic [3:0]  gate_state;
   logic [3:0]  trig_state;
   logic [3:0]  trig_seen [2];
   logic [7:0]  mono_prev [3];
   logic        common_trig;
   logic [15:0] track_state;

   mnva_pkg::rsp_payload_type pending_beats [$];
   logic [6:0]                held_notes [$];
   int                        mismatch_count = 0;
   int                        hold_requests  = 0;

   // directed stimulus: typed expectations where they are plain
   typedef struct {
      logic [6:0]                note;
      logic                      pressed;
      logic                      typed;
      mnva_pkg::rsp_payload_type beat;
   } directed_row_type;

   localparam mnva_pkg::rsp_payload_type NO_BEAT = '0;

   directed_row_type directed_rows [] = '{
      '{7'd36,  1'b1, 1'b1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0, 4'hF, 4'hF, 1'b1, 1'b1, 16'd0}},
      '{7'd96,  1'b1, 1'b1, '{8'sd60, 8'sd60, 8'sd60, 8'sd60, 4'hF, 4'hF, 1'b1, 1'b0,
                              16'h8000}},
      '{7'd127, 1'b1, 1'b1, '{8'sd91, 8'sd91, 8'sd91, 8'sd91, 4'hF, 4'hF, 1'b1, 1'b1,
                              16'h8000}},
      '{7'd0,   1'b1, 1'b1, '{-8'sd36, -8'sd36, -8'sd36, -8'sd36, 4'hF, 4'hF, 1'b1, 1'b0,
                              16'd0}},
      '{7'd0,   1'b0, 1'b0, NO_BEAT},
      '{7'd127, 1'b0, 1'b0, NO_BEAT},
      '{7'd96,  1'b0, 1'b0, NO_BEAT},
      '{7'd36,  1'b0, 1'b0, NO_BEAT},
      '{7'd0,   1'b1, 1'b0, NO_BEAT},
      '{7'd0,   1'b0, 1'b0, NO_BEAT},
      '{7'd127, 1'b1, 1'b0, NO_BEAT},
      '{7'd127, 1'b1, 1'b0, NO_BEAT},
      '{7'd64,  1'b1, 1'b0, NO_BEAT},
      '{7'd127, 1'b0, 1'b0, NO_BEAT},
      '{7'd64,  1'b0, 1'b0, NO_BEAT},
      '{7'd5,   1'b0, 1'b0, NO_BEAT},
      '{7'd85,  1'b1, 1'b0, NO_BEAT},
      '{7'd42,  1'b1, 1'b0, NO_BEAT},
      '{7'd85,  1'b0, 1'b0, NO_BEAT},
      '{7'd42,  1'b0, 1'b0, NO_BEAT}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [15:0] track_value(input logic [7:0] note);
      int num;
      int den;
      num = int'(note) - int'(cfg_track_low);
      den = int'(cfg_track_high) - int'(cfg_track_low);
      if (den == 0) return 16'h8000;
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (num <= 0) return 16'd0;
      if (num >= den) return 16'h8000;
      return 16'((num * 32768) / den);
   endfunction

   task automatic predict_reset();
      cfg_mode       = mnva_pkg::MODE_RESET;
      cfg_gate_hold  = 1'b0;
      cfg_zero_key   = mnva_pkg::ZERO_KEY_RESET;
      cfg_track_low  = mnva_pkg::TRACK_LOW_RESET;
      cfg_track_high = mnva_pkg::TRACK_HIGH_RESET;
      foreach (slot_note[i]) slot_note[i] = mnva_pkg::EMPTY_NOTE;
      slot_ptr = '0;
      for (int i = 0; i < 4; i++) begin
         voice_prev[i]  = mnva_pkg::EMPTY_NOTE;
         voice_owner[i] = mnva_pkg::EMPTY_NOTE;
         voice_pitch[i] = '0;
      end
      gate_state   = '0;
      trig_state   = '0;
      trig_seen[0] = '0;
      trig_seen[1] = '0;
      foreach (mono_prev[i]) mono_prev[i] = '0;
      common_trig  = 1'b0;
      track_state  = '0;
   endtask

   // note memory update for the current mode
   task automatic store_event(input logic [7:0] note, input logic on);
      logic [3:0] p;
      int         scan;
      if (!on) begin
         scan = (cfg_mode == mnva_pkg::MODE_POLY_RR) ? 4 : SLOTS;
         for (int i = 0; i < scan; i++)
            if (slot_note[i] == note) slot_note[i] = mnva_pkg::EMPTY_NOTE;
         return;
      end
      case (cfg_mode)
         mnva_pkg::MODE_MONO_LAST: begin
            p = slot_ptr;
            while (slot_note[p] == mnva_pkg::EMPTY_NOTE) begin
               p = p - 4'd1;
               if (p == slot_ptr) begin
                  slot_ptr     = '0;
                  slot_note[0] = note;
                  return;
               end
            end
            slot_ptr = p + 4'd1;
            slot_note[slot_ptr] = note;
         end
         mnva_pkg::MODE_POLY_RR: begin
            for (int i = 0; i < 4; i++)
               if (voice_owner[i] == note) begin
                  slot_note[i] = note;
                  return;
               end
            for (int i = 0; i < 4; i++) begin
               p        = slot_ptr & 4'd3;
               slot_ptr = (p + 4'd1) & 4'd3;
               if (slot_note[p] == mnva_pkg::EMPTY_NOTE) begin
                  slot_note[p]   = note;
                  voice_owner[p] = note;
                  return;
               end
            end
            p              = slot_ptr & 4'd3;
            slot_note[p]   = note;
            voice_owner[p] = note;
            slot_ptr       = (p + 4'd1) & 4'd3;
         end
         default: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_note[i] == mnva_pkg::EMPTY_NOTE) begin
                  slot_note[i] = note;
                  return;
               end
         end
      endcase
   endtask

   task automatic mono_voices(input logic found, input logic [7:0] note,
                              input logic [7:0] track_note, input int idx);
      if (!found) begin
         gate_state     = cfg_gate_hold ? mnva_pkg::ALL_VOICES : 4'h0;
         mono_prev[idx] = '0;
         return;
      end
      for (int i = 0; i < 4; i++) voice_pitch[i] = note - {1'b0, cfg_zero_key};
      if (!gate_state[0]) trig_state = trig_state ^ mnva_pkg::ALL_VOICES;
      gate_state = mnva_pkg::ALL_VOICES;
      if (note != mono_prev[idx]) common_trig = ~common_trig;
      mono_prev[idx] = note;
      track_state    = track_value(track_note);
   endtask

   task automatic poly_voices(input logic rr);
      logic       any;
      logic [7:0] top;
      logic [7:0] n;
      any = 1'b0;
      top = '0;
      for (int i = 0; i < 4; i++) begin
         n = slot_note[i];
         if (rr && n == voice_prev[i]) continue;
         if (n != mnva_pkg::EMPTY_NOTE) begin
            voice_pitch[i] = n - {1'b0, cfg_zero_key};
            gate_state[i]  = 1'b1;
            if (n != voice_prev[i]) trig_state[i] = ~trig_state[i];
            if (!any || n > top) top = n;
            any = 1'b1;
         end else begin
            gate_state[i] = cfg_gate_hold;
         end
      end
      for (int i = 0; i < 4; i++) voice_prev[i] = slot_note[i];
      if (trig_state != trig_seen[rr]) begin
         trig_seen[rr] = trig_state;
         common_trig   = ~common_trig;
      end
      if (!rr && any) track_state = track_value(top);
   endtask

   // one event through the shadow allocator
   task automatic predict_event(input logic [6:0] note_in, input logic on,
                                output mnva_pkg::rsp_payload_type beat);
      logic [7:0] note;
      logic [7:0] top;
      logic [7:0] bottom;
      logic [3:0] p;
      logic       found;
      note  = {1'b0, note_in};
      top   = '0;
      bottom = '0;
      found = 1'b0;
      store_event(note, on);
      case (cfg_mode)
         mnva_pkg::MODE_MONO_LOW, mnva_pkg::MODE_MONO_HIGH: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_note[i] == mnva_pkg::EMPTY_NOTE) continue;
               if (!found || slot_note[i] > top) top = slot_note[i];
               if (!found || slot_note[i] < bottom) bottom = slot_note[i];
               found = 1'b1;
            end
            if (cfg_mode == mnva_pkg::MODE_MONO_LOW) mono_voices(found, bottom, top, 0);
            else mono_voices(found, top, top, 1);
         end
         mnva_pkg::MODE_MONO_LAST: begin
            p = slot_ptr;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_note[p] != mnva_pkg::EMPTY_NOTE) begin
                  found = 1'b1;
                  break;
               end
               p = p - 4'd1;
            end
            mono_voices(found, found ? slot_note[p] : 8'd0,
                        found ? slot_note[p] : 8'd0, 2);
         end
         default: poly_voices(cfg_mode == mnva_pkg::MODE_POLY_RR);
      endcase
      beat.pitch0         = voice_pitch[0];
      beat.pitch1         = voice_pitch[1];
      beat.pitch2         = voice_pitch[2];
      beat.pitch3         = voice_pitch[3];
      beat.voice_gates    = gate_state;
      beat.voice_triggers = trig_state;
      beat.common_gate    = |gate_state;
      beat.common_trigger = common_trig;
      beat.key_track      = track_state;
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      mismatch_count++;
   endtask

   // result side: check beats and stall on a pattern of its own
   int ready_style = 0;
   int style_left  = 0;
   int hold_left   = 0;
   int hold_served = 0;

   always @(posedge clock) begin
      mnva_pkg::rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_bus.pitch0 !== want.pitch0)
               report_mismatch("pitch0", rsp_bus.pitch0, want.pitch0);
            if (rsp_bus.pitch1 !== want.pitch1)
               report_mismatch("pitch1", rsp_bus.pitch1, want.pitch1);
            if (rsp_bus.pitch2 !== want.pitch2)
               report_mismatch("pitch2", rsp_bus.pitch2, want.pitch2);
            if (rsp_bus.pitch3 !== want.pitch3)
               report_mismatch("pitch3", rsp_bus.pitch3, want.pitch3);
            if (rsp_bus.voice_gates !== want.voice_gates)
               report_mismatch("voice_gates", rsp_bus.voice_gates, want.voice_gates);
            if (rsp_bus.voice_triggers !== want.voice_triggers)
               report_mismatch("voice_triggers", rsp_bus.voice_triggers,
                               want.voice_triggers);
            if (rsp_bus.common_gate !== want.common_gate)
               report_mismatch("common_gate", rsp_bus.common_gate, want.common_gate);
            if (rsp_bus.common_trigger !== want.common_trigger)
               report_mismatch("common_trigger", rsp_bus.common_trigger,
                               want.common_trigger);
            if (rsp_bus.key_track !== want.key_track)
               report_mismatch("key_track", rsp_bus.key_track, want.key_track);
         end
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (style_left == 0) begin
         ready_style = $urandom_range(0, 3);
         style_left  = $urandom_range(50, 300);
      end else begin
         style_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (ready_style)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ~rsp_bus.ready;
            2:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // offer one event and hold it until taken
   task automatic send_event(input logic [6:0] note, input logic on,
                             input logic typed, input mnva_pkg::rsp_payload_type typed_beat);
      mnva_pkg::rsp_payload_type beat;
      req_bus.valid       <= 1'b1;
      req_bus.note_number <= note;
      req_bus.pressed     <= on;
      do @(posedge clock); while (!req_bus.ready);
      predict_event(note, on, beat);
      pending_beats.push_back(typed ? typed_beat : beat);
   endtask

   task automatic idle_cycles(input int n);
      if (n == 0) return;
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      idle_cycles(1);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register write; the write enable is low again before the task returns
   task automatic csr_write(input mnva_pkg::csr_index_type idx, input logic [6:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         mnva_pkg::CSR_MODE:
            if (data[2:0] <= mnva_pkg::MODE_POLY_RR) cfg_mode = mnva_pkg::mode_type'(data[2:0]);
         mnva_pkg::CSR_GATE_HOLD:  cfg_gate_hold  = data[0];
         mnva_pkg::CSR_ZERO_KEY:   cfg_zero_key   = data;
         mnva_pkg::CSR_TRACK_LOW:  cfg_track_low  = data;
         mnva_pkg::CSR_TRACK_HIGH: cfg_track_high = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [6:0] pick_key();
      case ($urandom_range(0, 4))
         0:       return 7'd0;
         1:       return 7'd127;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // random event: mostly held-note play, some noise
   task automatic next_event(input int base, input int span,
                             output logic [6:0] note, output logic on);
      int k;
      if ($urandom_range(0, 99) < 12) begin
         note = 7'($urandom);
         on   = 1'($urandom);
      end else if (held_notes.size() == 0 ||
                   (held_notes.size() < 20 && $urandom_range(0, 99) < 58)) begin
         case ($urandom_range(0, 19))
            0:       note = 7'd0;
            1:       note = 7'd127;
            default: note = 7'(base + $urandom_range(0, span));
         endcase
         on = 1'b1;
         held_notes.push_back(note);
      end else begin
         k    = $urandom_range(0, held_notes.size() - 1);
         note = held_notes[k];
         on   = 1'b0;
      end
      if (!on) begin
         for (int i = held_notes.size() - 1; i >= 0; i--)
            if (held_notes[i] == note) held_notes.delete(i);
      end
   endtask

   // stimulus
   initial begin
      int         burst_left;
      int         base;
      int         span;
      logic [6:0] note;
      logic       on;
      logic [6:0] lo;
      logic [6:0] hi;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.note_number <= '0;
      req_bus.pressed     <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_index           <= mnva_pkg::CSR_MODE;
      csr_write_data      <= '0;
      predict_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows in the reset configuration
      foreach (directed_rows[r]) begin
         send_event(directed_rows[r].note, directed_rows[r].pressed,
                    directed_rows[r].typed, directed_rows[r].beat);
         idle_cycles($urandom_range(0, 3));
      end

      // random phases over every mode, with random register settings
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         csr_write(mnva_pkg::CSR_MODE, 7'(ph % 5));
         if ($urandom_range(0, 3) == 0)
            csr_write(mnva_pkg::CSR_MODE, 7'($urandom_range(5, 7)));
         if ($urandom_range(0, 3) == 0)
            csr_write(mnva_pkg::CSR_MODE, {4'($urandom), 3'(ph % 5)});
         csr_write(mnva_pkg::CSR_GATE_HOLD, {6'($urandom), ph[0] ^ ph[2]});
         csr_write(mnva_pkg::CSR_ZERO_KEY, pick_key());
         lo = pick_key();
         hi = pick_key();
         case (ph % 4)
            0: hi = lo;
            1: begin lo = 7'd0; hi = 7'd127; end
            default: ;
         endcase
         csr_write(mnva_pkg::CSR_TRACK_LOW, lo);
         csr_write(mnva_pkg::CSR_TRACK_HIGH, hi);

         held_notes.delete();
         span       = ($urandom_range(0, 2) == 0) ? 127 : 23;
         base       = $urandom_range(0, 127 - span);
         burst_left = $urandom_range(1, 12);
         for (int k = 0; k < PHASE_LEN; k++) begin
            if (ph == 3 && k == 10) hold_requests++;
            next_event(7'(base), span, note, on);
            send_event(note, on, 1'b0, NO_BEAT);
            burst_left--;
            if (burst_left == 0) begin
               idle_cycles((ph % 5 == 1) ? 0 : $urandom_range(1, 40));
               burst_left = $urandom_range(1, 12);
            end
         end
      end

      drain();
      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
